### rtl/core/hsslr_pkg.sv
// ----------------------------------------------------------------------------
// hsslr_pkg
// Shared types, constants and coil tables for the half-step stepper sequencer.
// ----------------------------------------------------------------------------
package hsslr_pkg;

  localparam int unsigned HoldW   = 16;
  localparam int unsigned PollW   = 8;
  localparam int unsigned RevW    = 10;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CoilW   = 4;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [HoldW-1:0] HoldReset = 16'd20;
  localparam logic [PollW-1:0] PollReset = 8'd10;
  localparam logic [RevW-1:0]  RevReset  = 10'd100;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POLL_TICKS     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REVERSE_CYCLES = 2'd2;

  typedef enum logic [1:0] {
    MODE_POLL = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_REV  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [PhaseW-1:0] phase_index;
    logic [HoldW-1:0]  tick_counter;
    logic [RevW-1:0]   cycles_left;
    logic              forward_enabled;
    logic              trigger_latched;
    logic [CoilW-1:0]  coil_hold;
  } seq_state_t;

  typedef struct packed {
    logic [CoilW-1:0] coil_pattern;
    logic             reversing;
    logic             forward_on;
  } seq_result_t;

  typedef struct packed {
    logic [HoldW-1:0] hold_ticks;
    logic [PollW-1:0] poll_ticks;
    logic [RevW-1:0]  reverse_cycles;
  } seq_cfg_t;

  function automatic logic [CoilW-1:0] fwd_coil(input logic [PhaseW-1:0] ph);
    logic [CoilW-1:0] c;
    unique case (ph)
      3'd0:    c = 4'h8;
      3'd1:    c = 4'hC;
      3'd2:    c = 4'h4;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h2;
      3'd5:    c = 4'h3;
      3'd6:    c = 4'h1;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

  function automatic logic [CoilW-1:0] rev_coil(input logic [PhaseW-1:0] ph);
    logic [CoilW-1:0] c;
    unique case (ph)
      3'd0:    c = 4'h8;
      3'd1:    c = 4'h9;
      3'd2:    c = 4'h1;
      3'd3:    c = 4'h3;
      3'd4:    c = 4'h2;
      3'd5:    c = 4'h6;
      3'd6:    c = 4'h4;
      default: c = 4'hC;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/hsslr_step.sv
// ----------------------------------------------------------------------------
// hsslr_step
// Next-state and result logic for one tick of the stepper sequencer.
// ----------------------------------------------------------------------------
module hsslr_step
  import hsslr_pkg::*;
(
  input  seq_state_t  cur,
  input  seq_cfg_t    cfg,
  input  logic        limit_switch_n,
  input  logic        other_switch_n,
  output seq_state_t  nxt,
  output seq_result_t res
);

  mode_t            mode_eff;
  logic [HoldW-1:0] hold_eff;
  logic [HoldW-1:0] wait_eff;
  logic [HoldW-1:0] tick_inc;
  logic             tick_zero;
  logic [PhaseW-1:0] phase_inc;
  seq_state_t       s;

  always_comb begin
    // the spare mode code behaves as the poll wait
    unique case (cur.mode)
      MODE_FWD: mode_eff = MODE_FWD;
      MODE_REV: mode_eff = MODE_REV;
      default:  mode_eff = MODE_POLL;
    endcase

    hold_eff  = (cfg.hold_ticks == '0) ? HoldW'(1) : cfg.hold_ticks;
    wait_eff  = (cfg.poll_ticks == '0) ? HoldW'(1) : HoldW'(cfg.poll_ticks);
    tick_zero = (cur.tick_counter == '0);
    tick_inc  = cur.tick_counter + HoldW'(1);
    phase_inc = cur.phase_index + PhaseW'(1);

    s      = cur;
    s.mode = mode_eff;

    // sample switches on the first poll tick, load coil on the first phase tick
    if (mode_eff == MODE_POLL && tick_zero) begin
      s.trigger_latched = !limit_switch_n && other_switch_n;
    end
    if (mode_eff == MODE_FWD && tick_zero) begin
      s.coil_hold = fwd_coil(cur.phase_index);
    end
    if (mode_eff == MODE_REV && tick_zero) begin
      s.coil_hold = rev_coil(cur.phase_index);
    end

    res.coil_pattern = s.coil_hold;
    res.reversing    = (mode_eff == MODE_REV);
    res.forward_on   = cur.forward_enabled;

    s.tick_counter = tick_inc;

    nxt = s;
    if (mode_eff == MODE_POLL) begin
      if (tick_inc >= wait_eff) begin
        nxt.tick_counter = '0;
        if (cur.forward_enabled) begin
          nxt.mode        = MODE_FWD;
          nxt.phase_index = '0;
        end else if (s.trigger_latched && cfg.reverse_cycles != '0) begin
          nxt.forward_enabled = 1'b0;
          nxt.mode            = MODE_REV;
          nxt.cycles_left     = cfg.reverse_cycles;
          nxt.phase_index     = '0;
        end else begin
          if (s.trigger_latched) begin
            nxt.forward_enabled = 1'b0;
          end
          nxt.mode = MODE_POLL;
        end
      end
    end else if (tick_inc >= hold_eff) begin
      nxt.tick_counter = '0;
      nxt.phase_index  = phase_inc;
      if (phase_inc == '0) begin
        if (mode_eff == MODE_FWD) begin
          if (s.trigger_latched) begin
            nxt.forward_enabled = 1'b0;
          end
          if (s.trigger_latched && cfg.reverse_cycles != '0) begin
            nxt.mode        = MODE_REV;
            nxt.cycles_left = cfg.reverse_cycles;
          end else begin
            nxt.mode = MODE_POLL;
          end
        end else begin
          nxt.cycles_left = cur.cycles_left - RevW'(1);
          if (cur.cycles_left == RevW'(1)) begin
            nxt.mode = MODE_POLL;
          end
        end
      end
    end
  end

endmodule

### rtl/core/half_step_stepper_limit_reverse.sv
// ----------------------------------------------------------------------------
// half_step_stepper_limit_reverse
// Half-step unipolar stepper sequencer that reverses after a limit trigger.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | limit_switch_n, other_switch_n
//  out_    | output    | out_valid/out_stall | coil_pattern, reversing, forward_on
//  cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
//  One tick enters per clock cycle while in_stall is low; it goes through
//  the input register, then the result register. The sequencer state
//  advances once per tick in the step logic between the two registers.
//  Reset is synchronous, active low, and returns the registers to
//  20 / 10 / 100 and the sequencer to the poll wait.
//  out_stall holds the result register; a full input register then raises in_stall.
// ----------------------------------------------------------------------------
module half_step_stepper_limit_reverse
  import hsslr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_limit_switch_n,
  input  logic               in_other_switch_n,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CoilW-1:0]   out_coil_pattern,
  output logic               out_reversing,
  output logic               out_forward_on,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata
);

  seq_cfg_t    cfg_r;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  seq_result_t step_res;
  seq_result_t res_r;
  logic        s1_valid_r;
  logic        s1_limit_r;
  logic        s1_other_r;
  logic        out_valid_r;
  logic        out_load;
  logic        step_fire;
  logic        s1_take;

  assign out_load  = !out_valid_r || !out_stall;
  assign step_fire = s1_valid_r && out_load;
  assign s1_take   = !s1_valid_r || step_fire;
  assign in_stall  = !s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks     <= HoldReset;
      cfg_r.poll_ticks     <= PollReset;
      cfg_r.reverse_cycles <= RevReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLD_TICKS:     cfg_r.hold_ticks     <= cfg_wdata[HoldW-1:0];
        CFG_POLL_TICKS:     cfg_r.poll_ticks     <= cfg_wdata[PollW-1:0];
        CFG_REVERSE_CYCLES: cfg_r.reverse_cycles <= cfg_wdata[RevW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_limit_r <= in_limit_switch_n;
      s1_other_r <= in_other_switch_n;
    end
  end

  hsslr_step u_step (
    .cur            (state_r),
    .cfg            (cfg_r),
    .limit_switch_n (s1_limit_r),
    .other_switch_n (s1_other_r),
    .nxt            (state_nxt),
    .res            (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode            <= MODE_POLL;
      state_r.phase_index     <= '0;
      state_r.tick_counter    <= '0;
      state_r.cycles_left     <= '0;
      state_r.forward_enabled <= 1'b1;
      state_r.trigger_latched <= 1'b0;
      state_r.coil_hold       <= '0;
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= step_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coil_pattern = res_r.coil_pattern;
  assign out_reversing    = res_r.reversing;
  assign out_forward_on   = res_r.forward_on;

endmodule

### rtl/core/hsslr_checker.sv
// ----------------------------------------------------------------------------
// hsslr_checker
// Port-level checks for the half-step stepper sequencer.
// ----------------------------------------------------------------------------
module hsslr_checker
  import hsslr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CoilW-1:0]   out_coil_pattern,
  input logic               out_reversing,
  input logic               out_forward_on
);

  logic fwd_off_seen_r;

  // remember that a delivered transaction showed forward stepping disabled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_off_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && !out_forward_on) begin
      fwd_off_seen_r <= 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rev_no_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reversing |-> !out_forward_on)
    else $error("reversing while forward stepping still enabled");

  a_fwd_stays_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fwd_off_seen_r |-> !out_forward_on)
    else $error("forward stepping enabled again");

  a_coil_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_coil_pattern) <= 2) &&
                  (out_coil_pattern != 4'h5) && (out_coil_pattern != 4'hA))
    else $error("illegal half-step coil pattern");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coil_pattern) &&
                               $stable(out_reversing) && $stable(out_forward_on))
    else $error("stalled result changed");

endmodule

bind half_step_stepper_limit_reverse hsslr_checker u_hsslr_checker (.*);
